// ===== rtl/i2c_master_bit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define I2CM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define I2CM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, segment descriptor, result type and the segment table.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes carried on the request channel
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // Reset value of the delay unit length, in ticks
   localparam logic [15:0] TPU_RESET = 16'd20;

   // Last segment index of each sequence
   localparam logic [4:0] LAST_SEG_WRITE = 5'd26;
   localparam logic [4:0] LAST_SEG_READ  = 5'd18;
   localparam logic [4:0] LAST_SEG_SHORT = 5'd2;

   // Highest phase value a running sequence can reach
   localparam logic [4:0] PHASE_MAX = LAST_SEG_WRITE + 5'd1;

   // One segment: line settings, hold length and end-of-segment actions
   typedef struct packed {
      logic       sda_set;
      logic       sda_val;
      logic       scl_set;
      logic       scl_val;
      logic [2:0] units;
      logic       sample;
      logic       shift;
      logic       last;
   } seg_type;

   // One result transaction
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic [7:0] rd_data;
      logic       done_res;
   } res_type;

   // Decode segment idx of sequence op; msb is the next bit to send and
   // bit_cnt the number of bits already shifted (write only)
   function automatic seg_type seg_info(input logic [2:0] op, input logic [4:0] idx,
                                        input logic msb, input logic [3:0] bit_cnt);
      seg_type    s;
      logic [4:0] base;
      logic [4:0] rem5;
      s    = '0;
      base = {1'b0, bit_cnt[2:0], 1'b0} + {2'b00, bit_cnt[2:0]};
      rem5 = idx - base;
      if (op == CMD_START) begin
         s.sda_set = 1'b1;
         s.scl_set = 1'b1;
         s.last    = (idx >= LAST_SEG_SHORT);
         priority if (idx == 5'd0) begin
            s.sda_val = 1'b1; s.scl_val = 1'b1; s.units = 3'd4;
         end else if (idx == 5'd1) begin
            s.sda_val = 1'b0; s.scl_val = 1'b1; s.units = 3'd7;
         end else begin
            s.sda_val = 1'b0; s.scl_val = 1'b0; s.units = 3'd2;
         end
      end else if (op == CMD_STOP) begin
         s.last = (idx >= LAST_SEG_SHORT);
         priority if (idx == 5'd0) begin
            s.sda_set = 1'b1; s.sda_val = 1'b0; s.units = 3'd1;
         end else if (idx == 5'd1) begin
            s.scl_set = 1'b1; s.scl_val = 1'b1; s.units = 3'd2;
         end else begin
            s.sda_set = 1'b1; s.sda_val = 1'b1;
            s.scl_set = 1'b1; s.scl_val = 1'b1; s.units = 3'd2;
         end
      end else if (op == CMD_WRITE) begin
         s.last = (idx >= LAST_SEG_WRITE);
         priority if (idx < 5'd24) begin
            s.units = 3'd1;
            priority if (rem5[1:0] == 2'd0) begin
               s.sda_set = 1'b1; s.sda_val = msb;
            end else if (rem5[1:0] == 2'd1) begin
               s.scl_set = 1'b1; s.scl_val = 1'b1;
            end else begin
               s.scl_set = 1'b1; s.scl_val = 1'b0; s.shift = 1'b1;
            end
         end else if (idx == 5'd24) begin
            s.units = 3'd2;
         end else if (idx == 5'd25) begin
            s.sda_set = 1'b1; s.sda_val = 1'b1;
            s.scl_set = 1'b1; s.scl_val = 1'b1; s.units = 3'd1;
         end else begin
            s.scl_set = 1'b1; s.scl_val = 1'b0; s.units = 3'd3;
         end
      end else begin
         s.last = (idx >= LAST_SEG_READ);
         priority if (idx < 5'd16) begin
            if (idx[0] == 1'b0) begin
               s.sda_set = 1'b1; s.sda_val = 1'b1;
               s.scl_set = 1'b1; s.scl_val = 1'b0; s.units = 3'd2;
            end else begin
               s.scl_set = 1'b1; s.scl_val = 1'b1; s.units = 3'd1; s.sample = 1'b1;
            end
         end else if (idx == 5'd16) begin
            s.sda_set = 1'b1; s.sda_val = 1'b0;
            s.scl_set = 1'b1; s.scl_val = 1'b0; s.units = 3'd2;
         end else if (idx == 5'd17) begin
            s.scl_set = 1'b1; s.scl_val = 1'b1; s.units = 3'd3;
         end else begin
            s.scl_set = 1'b1; s.scl_val = 1'b0; s.units = 3'd2;
         end
      end
      return s;
   endfunction

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master: each request transaction is one tick, optionally
// carrying a start, stop, write byte or read byte command; each tick returns
// the SCL/SDA drive levels, busy, last byte read and a done pulse.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | cmd, wr_byte, sda_in
//  rsp     | out       | rsp_valid / rsp_ready  | scl, sda_out, busy_res, rd_data, done_res
//  csr     | in        | csr_valid / csr_ready  | wdata = ticks per delay unit
//
// One request transaction is taken per cycle unless a stalled response holds
// the output register; its response appears there the cycle after acceptance.
// The sequencer update and result for a tick are one pass of logic between
// the sequencer state and the output register.
// Reset: idle, lines released high, ticks per unit 20; csr always ready.
// A stalled response blocks a new request only while the output register is
// full and rsp_ready is low.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_wr_byte,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_rd_data,
   output logic        rsp_done_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   logic [15:0]       tpu_ff;
   logic              rsp_valid_ff;
   i2cm_pkg::res_type rsp_ff;
   i2cm_pkg::res_type res;
   logic              accept;

   // Take a transaction whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Hold the delay unit length
   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= i2cm_pkg::TPU_RESET;
      end else if (csr_valid) begin
         tpu_ff <= csr_wdata;
      end
   end

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cmd     (req_cmd),
      .wr_byte (req_wr_byte),
      .sda_in  (req_sda_in),
      .tpu     (tpu_ff),
      .res     (res)
   );

   // Output register: fill on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_scl      = rsp_ff.scl;
   assign rsp_sda_out  = rsp_ff.sda_out;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_rd_data  = rsp_ff.rd_data;
   assign rsp_done_res = rsp_ff.done_res;

   `I2CM_ASSERT_IMPL(a_done_not_busy, rsp_valid_ff && rsp_ff.done_res, !rsp_ff.busy_res)
   `I2CM_ASSERT_NEXT(a_accept_fills, accept, rsp_valid_ff)
   `I2CM_ASSERT_IMPL(a_ready_when_empty, !rsp_valid_ff, req_ready)

endmodule

// ===== rtl/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Segment sequencer state; advances one tick per accepted transaction and
// presents the result of that tick combinationally.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2cm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [2:0]         cmd,
   input  logic [7:0]         wr_byte,
   input  logic               sda_in,
   input  logic [15:0]        tpu,
   output i2cm_pkg::res_type  res
);

   logic [4:0]  phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [15:0] unit_ff, unit_in;
   logic [2:0]  hold_ff, hold_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_level_ff, scl_level_in;
   logic        sda_level_ff, sda_level_in;
   logic [7:0]  rd_ff, rd_in;

   logic [15:0]       tpu_eff;
   logic              load;
   logic              done;
   i2cm_pkg::seg_type seg_load;
   i2cm_pkg::seg_type seg_end;

   // Treat a zero unit length as one tick
   assign tpu_eff = (tpu == 16'd0) ? 16'd1 : tpu;

   // Work out the state after this tick
   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      unit_in      = unit_ff;
      hold_in      = hold_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      scl_level_in = scl_level_ff;
      sda_level_in = sda_level_ff;
      rd_in        = rd_ff;
      load         = 1'b0;
      done         = 1'b0;
      seg_load     = '0;
      seg_end      = '0;

      // Launch a command when idle, or move to the next segment
      if (phase_ff == 5'd0) begin
         if (cmd == i2cm_pkg::CMD_START || cmd == i2cm_pkg::CMD_STOP ||
             cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ) begin
            op_in    = cmd;
            bit_in   = 4'd0;
            shift_in = (cmd == i2cm_pkg::CMD_WRITE) ? wr_byte : 8'd0;
            phase_in = 5'd1;
            load     = 1'b1;
         end
      end else if (hold_ff == 3'd0) begin
         phase_in = phase_ff + 5'd1;
         load     = 1'b1;
      end

      // Drive the lines for a freshly loaded segment
      if (load) begin
         seg_load = i2cm_pkg::seg_info(op_in, phase_in - 5'd1, shift_in[7], bit_in);
         if (seg_load.sda_set) begin
            sda_level_in = seg_load.sda_val;
         end
         if (seg_load.scl_set) begin
            scl_level_in = seg_load.scl_val;
         end
         hold_in = seg_load.units;
         unit_in = 16'd0;
      end

      // Count the tick; close the unit, then the segment, then the sequence
      if (phase_in != 5'd0) begin
         unit_in = unit_in + 16'd1;
         if (unit_in >= tpu_eff) begin
            unit_in = 16'd0;
            if (hold_in != 3'd0) begin
               hold_in = hold_in - 3'd1;
            end
            if (hold_in == 3'd0) begin
               seg_end = i2cm_pkg::seg_info(op_in, phase_in - 5'd1, shift_in[7], bit_in);
               if (seg_end.sample) begin
                  shift_in = {shift_in[6:0], sda_in};
                  bit_in   = bit_in + 4'd1;
               end
               if (seg_end.shift) begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
               end
               if (seg_end.last) begin
                  if (op_in == i2cm_pkg::CMD_READ) begin
                     rd_in = shift_in;
                  end
                  phase_in = 5'd0;
                  done     = 1'b1;
               end
            end
         end
      end
   end

   // Present the result of this tick
   assign res.scl      = scl_level_in;
   assign res.sda_out  = sda_level_in;
   assign res.busy_res = (phase_in != 5'd0);
   assign res.rd_data  = rd_in;
   assign res.done_res = done;

   // Hold state; advance once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 5'd0;
         op_ff        <= 3'd0;
         unit_ff      <= 16'd0;
         hold_ff      <= 3'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         scl_level_ff <= 1'b1;
         sda_level_ff <= 1'b1;
         rd_ff        <= 8'd0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         unit_ff      <= unit_in;
         hold_ff      <= hold_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         scl_level_ff <= scl_level_in;
         sda_level_ff <= sda_level_in;
         rd_ff        <= rd_in;
      end
   end

   `I2CM_ASSERT_IMPL(a_hold_zero_count_zero, phase_ff != 5'd0 && hold_ff == 3'd0, unit_ff == 16'd0)
   `I2CM_ASSERT_IMPL(a_busy_op_known, phase_ff != 5'd0, op_ff == i2cm_pkg::CMD_START || op_ff == i2cm_pkg::CMD_STOP || op_ff == i2cm_pkg::CMD_WRITE || op_ff == i2cm_pkg::CMD_READ)
   `I2CM_ASSERT_IMPL(a_phase_in_range, 1'b1, phase_ff <= i2cm_pkg::PHASE_MAX && bit_ff <= 4'd8)

endmodule
